### rtl/rate_based_ecn_marker_assert.svh
// Assertion macros for the rate-based ECN marker.
// Included by the top level; needs no other file.
`ifndef RATE_BASED_ECN_MARKER_ASSERT_SVH
`define RATE_BASED_ECN_MARKER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RBEM_ASSERT_HOLDS(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RBEM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rbem_pkg.sv
// Shared types, widths and constants of the rate-based ECN marker.
// Used by every RTL module of the block; depends on nothing.
package rbem_pkg;

    localparam int NUM_PORTS_DEF = 4;

    localparam int PORT_W   = 2;
    localparam int LEN_W    = 16;
    localparam int TIME_W   = 40;
    localparam int QPK_W    = 16;
    localparam int RND_W    = 16;
    localparam int ECN_W    = 2;
    localparam int PROB_W   = 17;
    localparam int WIN_W    = 40;
    localparam int AVG_W    = 48;
    localparam int RATE_W   = 16;
    localparam int RATES_W  = 64;
    localparam int MASK_W   = 4;
    localparam int WEIGHT_W = 17;
    localparam int IVL_W    = 24;

    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 27;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 88;
    localparam int RB_W     = 27;
    localparam int DEN_W    = 67;
    localparam int SCALED_W = 68;
    localparam int REM_W    = 84;
    localparam int DIV_STEPS = 17;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 24;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam int IN_PORT_LSB = 0;
    localparam int IN_LEN_LSB  = IN_PORT_LSB + PORT_W;
    localparam int IN_NOW_LSB  = IN_LEN_LSB + LEN_W;
    localparam int IN_QPK_LSB  = IN_NOW_LSB + TIME_W;
    localparam int IN_RND_LSB  = IN_QPK_LSB + QPK_W;
    localparam int IN_ECN_LSB  = IN_RND_LSB + RND_W;
    localparam int IN_USED_W   = IN_ECN_LSB + ECN_W;
    localparam int OUT_USED_W  = 2 + PROB_W;

    localparam logic [10:0]         PKT_BYTES = 11'd1500;
    localparam logic [19:0]         MICRO     = 20'd1000000;
    localparam logic [PROB_W-1:0]   ONE_Q16   = 17'h10000;

    localparam logic [RATES_W-1:0]  RST_PORT_RATES  = 64'h0096_0096_0096_0096;
    localparam logic [MASK_W-1:0]   RST_MARK_MASK   = 4'h0;
    localparam logic [WEIGHT_W-1:0] RST_AVG_WEIGHT  = 17'd6554;
    localparam logic [IVL_W-1:0]    RST_INTERVAL_US = 24'd1000;
    localparam logic [WEIGHT_W-1:0] RST_MAX_PERCENT = 17'h10000;

    localparam logic [2:0] REG_PORT_RATES  = 3'd0;
    localparam logic [2:0] REG_MARK_MASK   = 3'd1;
    localparam logic [2:0] REG_AVG_WEIGHT  = 3'd2;
    localparam logic [2:0] REG_INTERVAL_US = 3'd3;
    localparam logic [2:0] REG_MAX_PERCENT = 3'd4;

    typedef struct packed {
        logic [RATES_W-1:0]  port_rates;
        logic [MASK_W-1:0]   mark_mask;
        logic [WEIGHT_W-1:0] avg_weight;
        logic [IVL_W-1:0]    interval_us;
        logic [WEIGHT_W-1:0] max_percent;
    } cfg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_QPK,
        MUL_RATE,
        MUL_W1_AVG_LO,
        MUL_W2_CUR_LO,
        MUL_W1_AVG_HI,
        MUL_W2_CUR_HI,
        MUL_RB_EL_LO,
        MUL_RB_EL_HI,
        MUL_AVG_LO_MIC,
        MUL_AVG_HI_MIC,
        MUL_MP_R0,
        MUL_MP_R1,
        MUL_MP_R2
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_S20,
        ACC_ADD_S24,
        ACC_ADD_S32,
        ACC_ADD_S64,
        ACC_SHR16_ADD
    } acc_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TEST,
        ST_QB,
        ST_CUR,
        ST_RB,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_A4,
        ST_AVG,
        ST_D1,
        ST_D2,
        ST_S1,
        ST_S2,
        ST_R0,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_DIVI,
        ST_DIV,
        ST_COMMIT,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     ld_in;
        logic     ld_cur;
        logic     ld_rb;
        logic     ld_avg;
        logic     ld_den;
        logic     ld_scaled;
        logic     div_init;
        logic     div_step;
        logic     commit;
        logic     decide;
    } dp_cmd_t;

    typedef struct packed {
        logic upd;
        logic ge;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/rbem_cfg.sv
// APB register file of the rate-based ECN marker.
// Depends on rbem_pkg for register layout and reset values.
module rbem_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rbem_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rbem_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rbem_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output rbem_pkg::cfg_t                    cfg
);
    import rbem_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_PORT_RATES:  cfg_next.port_rates  = pwdata[RATES_W-1:0];
                REG_MARK_MASK:   cfg_next.mark_mask   = pwdata[MASK_W-1:0];
                REG_AVG_WEIGHT:  cfg_next.avg_weight  = pwdata[WEIGHT_W-1:0];
                REG_INTERVAL_US: cfg_next.interval_us = pwdata[IVL_W-1:0];
                REG_MAX_PERCENT: cfg_next.max_percent = pwdata[WEIGHT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PORT_RATES:  prdata = APB_DATA_W'(cfg_reg.port_rates);
            REG_MARK_MASK:   prdata = APB_DATA_W'(cfg_reg.mark_mask);
            REG_AVG_WEIGHT:  prdata = APB_DATA_W'(cfg_reg.avg_weight);
            REG_INTERVAL_US: prdata = APB_DATA_W'(cfg_reg.interval_us);
            REG_MAX_PERCENT: prdata = APB_DATA_W'(cfg_reg.max_percent);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.port_rates  <= RST_PORT_RATES;
            cfg_reg.mark_mask   <= RST_MARK_MASK;
            cfg_reg.avg_weight  <= RST_AVG_WEIGHT;
            cfg_reg.interval_us <= RST_INTERVAL_US;
            cfg_reg.max_percent <= RST_MAX_PERCENT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/rbem_ctrl.sv
// Sequencer of the rate-based ECN marker: steps the datapath through
// accept, interval update, division and decision. Depends on rbem_pkg.
module rbem_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rbem_pkg::dp_stat_t  stat,
    output rbem_pkg::dp_cmd_t   cmd
);
    import rbem_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_tready      = 1'b0;
        cmd.mul_sel   = MUL_NONE;
        cmd.acc_op    = ACC_HOLD;
        cmd.ld_in     = 1'b0;
        cmd.ld_cur    = 1'b0;
        cmd.ld_rb     = 1'b0;
        cmd.ld_avg    = 1'b0;
        cmd.ld_den    = 1'b0;
        cmd.ld_scaled = 1'b0;
        cmd.div_init  = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.commit    = 1'b0;
        cmd.decide    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: state_next = stat.upd ? ST_QB : ST_DECIDE;
            ST_QB: begin
                cmd.mul_sel = MUL_QPK;
                state_next  = ST_CUR;
            end
            ST_CUR: begin
                cmd.ld_cur  = 1'b1;
                cmd.mul_sel = MUL_RATE;
                state_next  = ST_RB;
            end
            ST_RB: begin
                cmd.ld_rb   = 1'b1;
                cmd.mul_sel = MUL_W1_AVG_LO;
                state_next  = ST_A1;
            end
            ST_A1: begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_W2_CUR_LO;
                state_next  = ST_A2;
            end
            ST_A2: begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_sel = MUL_W1_AVG_HI;
                state_next  = ST_A3;
            end
            ST_A3: begin
                cmd.acc_op  = ACC_SHR16_ADD;
                cmd.mul_sel = MUL_W2_CUR_HI;
                state_next  = ST_A4;
            end
            ST_A4: begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_sel = MUL_RB_EL_LO;
                state_next  = ST_AVG;
            end
            ST_AVG: begin
                cmd.ld_avg  = 1'b1;
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_RB_EL_HI;
                state_next  = ST_D1;
            end
            ST_D1: begin
                cmd.acc_op  = ACC_ADD_S20;
                cmd.mul_sel = MUL_AVG_LO_MIC;
                state_next  = ST_D2;
            end
            ST_D2: begin
                cmd.ld_den  = 1'b1;
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_AVG_HI_MIC;
                state_next  = ST_S1;
            end
            ST_S1: begin
                cmd.acc_op = ACC_ADD_S24;
                state_next = ST_S2;
            end
            ST_S2: begin
                cmd.ld_scaled = 1'b1;
                state_next    = ST_R0;
            end
            ST_R0: begin
                cmd.mul_sel = MUL_MP_R0;
                state_next  = stat.ge ? ST_COMMIT : ST_R1;
            end
            ST_R1: begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_MP_R1;
                state_next  = ST_R2;
            end
            ST_R2: begin
                cmd.acc_op  = ACC_ADD_S32;
                cmd.mul_sel = MUL_MP_R2;
                state_next  = ST_R3;
            end
            ST_R3: begin
                cmd.acc_op = ACC_ADD_S64;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = CNT_W'(DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_COMMIT;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (stat.out_free) begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/rbem_dp.sv
// Datapath of the rate-based ECN marker: window and average state, shared
// multiplier with accumulator, restoring divider, output register. Uses rbem_pkg.
module rbem_dp #(
    parameter int NUM_PORTS = rbem_pkg::NUM_PORTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rbem_pkg::cfg_t                 cfg,
    input  rbem_pkg::dp_cmd_t              cmd,
    output rbem_pkg::dp_stat_t             stat,
    input  logic [rbem_pkg::PORT_W-1:0]    port_index,
    input  logic [rbem_pkg::LEN_W-1:0]     byte_length,
    input  logic [rbem_pkg::TIME_W-1:0]    now_us,
    input  logic [rbem_pkg::QPK_W-1:0]     queue_packets,
    input  logic [rbem_pkg::RND_W-1:0]     random_value,
    input  logic [rbem_pkg::ECN_W-1:0]     ecn_in,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           drop,
    output logic                           set_ecn,
    output logic [rbem_pkg::PROB_W-1:0]    probability
);
    import rbem_pkg::*;

    localparam logic [PORT_W-1:0] LAST_PORT = PORT_W'(NUM_PORTS - 1);

    // block state
    logic [WIN_W-1:0]    wb_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [TIME_W-1:0]   ws_reg;
    logic [PROB_W-1:0]   prob_reg;
    logic                skip_reg;
    logic                out_valid_reg;

    // per-item payload
    logic [PORT_W-1:0]   port_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [QPK_W-1:0]    qpk_reg;
    logic [RND_W-1:0]    rnd_reg;
    logic [ECN_W-1:0]    ecn_in_reg;
    logic                upd_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [WIN_W-1:0]    cur_reg;
    logic [RB_W-1:0]     rb_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    dsh_reg;
    logic [PROB_W-1:0]   quot_reg;
    logic                ge_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                drop_reg;
    logic                set_ecn_reg;
    logic [PROB_W-1:0]   prob_out_reg;

    logic [PORT_W-1:0]   port_clamp;
    logic [RATE_W-1:0]   rate;
    logic                marking;
    logic [WEIGHT_W-1:0] w1;
    logic [WEIGHT_W-1:0] w2;
    logic [WEIGHT_W-1:0] mp;
    logic [WIN_W:0]      wb_sum;
    logic [WIN_W:0]      cur_sum;
    logic [TIME_W:0]     due_time;
    logic                upd_calc;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod_full;
    logic [ACC_W-1:0]    prod_ext;
    logic [ACC_W-1:0]    acc_next;
    logic                ge_calc;
    logic                rem_ge;
    logic                sel;
    logic                drop_c;
    logic                set_c;
    logic                skip_c;

    assign port_clamp = (port_index > LAST_PORT) ? LAST_PORT : port_index;
    assign rate       = cfg.port_rates[RATE_W*port_reg +: RATE_W];
    assign marking    = cfg.mark_mask[port_reg];
    assign w2         = (cfg.avg_weight > ONE_Q16) ? ONE_Q16 : cfg.avg_weight;
    assign w1         = ONE_Q16 - w2;
    assign mp         = (cfg.max_percent > ONE_Q16) ? ONE_Q16 : cfg.max_percent;

    assign wb_sum   = {1'b0, wb_reg} + (WIN_W+1)'(byte_length);
    assign due_time = {1'b0, ws_reg} + (TIME_W+1)'(cfg.interval_us);
    assign upd_calc = {1'b0, now_us} >= due_time;
    assign cur_sum  = {1'b0, wb_reg} + (WIN_W+1)'(prod_reg[RB_W-1:0]);

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_QPK: begin
                mul_a = MUL_A_W'(qpk_reg);
                mul_b = MUL_B_W'(PKT_BYTES);
            end
            MUL_RATE: begin
                mul_a = MUL_A_W'(rate);
                mul_b = MUL_B_W'(PKT_BYTES);
            end
            MUL_W1_AVG_LO: begin
                mul_a = MUL_A_W'(avg_reg[15:0]);
                mul_b = MUL_B_W'(w1);
            end
            MUL_W2_CUR_LO: begin
                mul_a = MUL_A_W'(cur_reg[15:0]);
                mul_b = MUL_B_W'(w2);
            end
            MUL_W1_AVG_HI: begin
                mul_a = avg_reg[AVG_W-1:16];
                mul_b = MUL_B_W'(w1);
            end
            MUL_W2_CUR_HI: begin
                mul_a = MUL_A_W'(cur_reg[WIN_W-1:16]);
                mul_b = MUL_B_W'(w2);
            end
            MUL_RB_EL_LO: begin
                mul_a = MUL_A_W'(elapsed_reg[19:0]);
                mul_b = rb_reg;
            end
            MUL_RB_EL_HI: begin
                mul_a = MUL_A_W'(elapsed_reg[TIME_W-1:20]);
                mul_b = rb_reg;
            end
            MUL_AVG_LO_MIC: begin
                mul_a = MUL_A_W'(avg_reg[23:0]);
                mul_b = MUL_B_W'(MICRO);
            end
            MUL_AVG_HI_MIC: begin
                mul_a = MUL_A_W'(avg_reg[AVG_W-1:24]);
                mul_b = MUL_B_W'(MICRO);
            end
            MUL_MP_R0: begin
                mul_a = rem_reg[31:0];
                mul_b = MUL_B_W'(mp);
            end
            MUL_MP_R1: begin
                mul_a = rem_reg[63:32];
                mul_b = MUL_B_W'(mp);
            end
            MUL_MP_R2: begin
                mul_a = MUL_A_W'(rem_reg[SCALED_W-1:64]);
                mul_b = MUL_B_W'(mp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb begin
        unique case (cmd.acc_op)
            ACC_HOLD:      acc_next = acc_reg;
            ACC_LOAD:      acc_next = prod_ext;
            ACC_ADD:       acc_next = acc_reg + prod_ext;
            ACC_ADD_S20:   acc_next = acc_reg + (prod_ext << 20);
            ACC_ADD_S24:   acc_next = acc_reg + (prod_ext << 24);
            ACC_ADD_S32:   acc_next = acc_reg + (prod_ext << 32);
            ACC_ADD_S64:   acc_next = acc_reg + (prod_ext << 64);
            ACC_SHR16_ADD: acc_next = (acc_reg >> 16) + prod_ext;
            default:       acc_next = acc_reg;
        endcase
    end

    assign ge_calc = (den_reg == '0) || (mp == '0)
                     || (acc_reg[SCALED_W-1:0] >= SCALED_W'(den_reg));
    assign rem_ge  = rem_reg >= dsh_reg;
    assign sel     = {1'b0, rnd_reg} < prob_reg;

    always_comb begin
        drop_c = 1'b0;
        set_c  = 1'b0;
        skip_c = skip_reg;
        if (sel) begin
            priority if (!marking) begin
                drop_c = 1'b1;
            end else if (ecn_in_reg != '0) begin
                skip_c = 1'b1;
            end else if (!skip_reg) begin
                set_c = 1'b1;
            end else begin
                skip_c = 1'b0;
            end
        end
    end

    assign stat.upd      = upd_reg;
    assign stat.ge       = ge_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid    = out_valid_reg;
    assign drop        = drop_reg;
    assign set_ecn     = set_ecn_reg;
    assign probability = prob_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg        <= '0;
            avg_reg       <= '0;
            ws_reg        <= '0;
            prob_reg      <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.ld_in) begin
                wb_reg <= wb_sum[WIN_W] ? '1 : wb_sum[WIN_W-1:0];
            end else if (cmd.commit) begin
                wb_reg <= '0;
            end
            if (cmd.ld_avg) begin
                avg_reg <= acc_reg[AVG_W-1:0];
            end
            if (cmd.commit) begin
                ws_reg   <= now_reg;
                prob_reg <= ge_reg ? ONE_Q16 : quot_reg;
            end
            if (cmd.decide) begin
                skip_reg      <= skip_c;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            port_reg    <= port_clamp;
            now_reg     <= now_us;
            qpk_reg     <= queue_packets;
            rnd_reg     <= random_value;
            ecn_in_reg  <= ecn_in;
            upd_reg     <= upd_calc;
            elapsed_reg <= now_us - ws_reg;
        end
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= prod_full;
        end
        acc_reg <= acc_next;
        if (cmd.ld_cur) begin
            cur_reg <= cur_sum[WIN_W] ? '1 : cur_sum[WIN_W-1:0];
        end
        if (cmd.ld_rb) begin
            rb_reg <= prod_reg[RB_W-1:0];
        end
        if (cmd.ld_den) begin
            den_reg <= acc_reg[DEN_W-1:0];
        end
        if (cmd.ld_scaled) begin
            ge_reg <= ge_calc;
        end
        if (cmd.ld_scaled || cmd.div_init) begin
            rem_reg <= acc_reg[REM_W-1:0];
        end else if (cmd.div_step && rem_ge) begin
            rem_reg <= rem_reg - dsh_reg;
        end
        if (cmd.div_init) begin
            dsh_reg  <= REM_W'(den_reg) << (DIV_STEPS - 1);
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[PROB_W-2:0], rem_ge};
        end
        if (cmd.decide) begin
            drop_reg     <= drop_c;
            set_ecn_reg  <= set_c;
            prob_out_reg <= prob_reg;
        end
    end

endmodule

### rtl/rate_based_ecn_marker.sv
// Top level of the rate-based ECN marker: APB registers, sequencer, datapath.
// Depends on rbem_pkg, rbem_cfg, rbem_ctrl, rbem_dp and the assertion header.
// Usage:
//   One request on the s_ channel per arriving packet, one result on the
//   m_ channel per request, in order. Registers are written over APB while
//   no request is in flight.
// Sequence:
//   A packet that does not close an update interval goes from a test state
//   straight to its decision. One that closes it first takes 10 steps of
//   the shared 32x27 multiplier and accumulator for backlog, average,
//   capacity and scaled average, 3 more for the dividend, then a 17-step
//   restoring divider; a saturated probability ends the dividend after its
//   first step and skips the divider. One packet is in flight at a time:
//   s_tready is high only when idle, after the last packet is decided.
// Reset:
//   aresetn clears the window count, average, window start, probability and
//   skip flag, loads register defaults and empties the output register.
// Stall:
//   The result waits in the output register while m_tready is low; the next
//   request is still taken and is held in its decision step until then.
`include "rate_based_ecn_marker_assert.svh"

module rate_based_ecn_marker #(
    parameter int NUM_PORTS = rbem_pkg::NUM_PORTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: port_index, byte_length, now_us, queue_packets, random_value, ecn_in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbem_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: drop, set_ecn, probability
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbem_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rbem_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rbem_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rbem_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import rbem_pkg::*;

    cfg_t              cfg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              out_drop;
    logic              out_set_ecn;
    logic [PROB_W-1:0] out_prob;

    rbem_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbem_dp #(
        .NUM_PORTS (NUM_PORTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .port_index    (s_tdata[IN_LEN_LSB-1:IN_PORT_LSB]),
        .byte_length   (s_tdata[IN_NOW_LSB-1:IN_LEN_LSB]),
        .now_us        (s_tdata[IN_QPK_LSB-1:IN_NOW_LSB]),
        .queue_packets (s_tdata[IN_RND_LSB-1:IN_QPK_LSB]),
        .random_value  (s_tdata[IN_ECN_LSB-1:IN_RND_LSB]),
        .ecn_in        (s_tdata[IN_USED_W-1:IN_ECN_LSB]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .drop          (out_drop),
        .set_ecn       (out_set_ecn),
        .probability   (out_prob)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_USED_W){1'b0}}, out_prob, out_set_ecn, out_drop};

    `RBEM_ASSERT_HOLDS(a_prob_range, aclk, aresetn, m_tvalid, out_prob <= ONE_Q16, "probability above one")
    `RBEM_ASSERT_HOLDS(a_drop_xor_mark, aclk, aresetn, m_tvalid, !(out_drop && out_set_ecn), "drop and mark together")
    `RBEM_ASSERT_HOLDS(a_drop_needs_prob, aclk, aresetn, m_tvalid && (out_drop || out_set_ecn), out_prob != '0, "action with zero probability")
    `RBEM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second request taken while busy")

endmodule

### tb/rbem_checker.sv
// Checker for the rate-based ECN marker: tracks APB register writes, predicts
// the drop / mark / probability verdict of each request and compares results.
// Depends on rbem_pkg only.
module rbem_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rbem_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rbem_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [rbem_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rbem_pkg::APB_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rbem_pkg::*;

    localparam logic [63:0] WIN_MAX = 64'hFF_FFFF_FFFF;

    // drop in the lowest bit, as on m_tdata
    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              set_ecn;
        logic              drop;
    } verdict_t;

    logic [RATES_W-1:0]  rates_cfg;
    logic [MASK_W-1:0]   mask_cfg;
    logic [WEIGHT_W-1:0] weight_cfg;
    logic [IVL_W-1:0]    ivl_cfg;
    logic [WEIGHT_W-1:0] ceil_cfg;

    logic [WIN_W-1:0]    win_bytes;
    logic [AVG_W-1:0]    ewma_bytes;
    logic [TIME_W-1:0]   win_start;
    logic [PROB_W-1:0]   cur_prob;
    logic                skip_flag;

    verdict_t expected_verdicts[$];
    verdict_t want;
    verdict_t got;

    function automatic logic [PROB_W-1:0] clamp_one(input logic [WEIGHT_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    task automatic judge_packet(input logic [S_TDATA_W-1:0] req, output verdict_t v);
        logic [PORT_W-1:0] port;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now;
        logic [QPK_W-1:0]  qpk;
        logic [RND_W-1:0]  rnd;
        logic [ECN_W-1:0]  ecn;
        logic              marking;
        logic [WIN_W:0]    wsum;
        logic [TIME_W:0]   deadline;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       cur;
        logic [127:0]      rate, w1, w2, acc, den, scaled, quot;
        logic [PROB_W-1:0] mp;
        port = req[IN_PORT_LSB +: PORT_W];
        len  = req[IN_LEN_LSB +: LEN_W];
        now  = req[IN_NOW_LSB +: TIME_W];
        qpk  = req[IN_QPK_LSB +: QPK_W];
        rnd  = req[IN_RND_LSB +: RND_W];
        ecn  = req[IN_ECN_LSB +: ECN_W];
        rate = '0;
        rate[RATE_W-1:0] = rates_cfg[port*RATE_W +: RATE_W];
        marking = mask_cfg[port];

        wsum = {1'b0, win_bytes} + (WIN_W+1)'(len);
        win_bytes = wsum[WIN_W] ? '1 : wsum[WIN_W-1:0];

        deadline = {1'b0, win_start} + (TIME_W+1)'(ivl_cfg);
        if ({1'b0, now} >= deadline) begin
            elapsed = now - win_start;
            w2 = '0;
            w2[PROB_W-1:0] = clamp_one(weight_cfg);
            w1 = 128'(ONE_Q16);
            w1 = w1 - w2;
            cur = 64'(win_bytes);
            cur = cur + 64'(qpk) * 64'(PKT_BYTES);
            if (cur > WIN_MAX)
                cur = WIN_MAX;
            acc = w1 * 128'(ewma_bytes >> 16) + w2 * 128'(cur >> 16)
                + ((w1 * 128'(ewma_bytes[15:0]) + w2 * 128'(cur[15:0])) >> 16);
            ewma_bytes = acc[AVG_W-1:0];
            mp = clamp_one(ceil_cfg);
            den = rate * 128'(PKT_BYTES) * 128'(elapsed);
            scaled = 128'(ewma_bytes);
            scaled = scaled * 128'(MICRO);
            if (den == '0 || mp == '0 || scaled >= den) begin
                cur_prob = ONE_Q16;
            end else begin
                quot = (scaled * 128'(mp)) / den;
                cur_prob = quot[PROB_W-1:0];
            end
            win_start = now;
            win_bytes = '0;
        end

        v = '0;
        v.prob = cur_prob;
        if ({1'b0, rnd} < cur_prob) begin
            if (!marking)
                v.drop = 1'b1;
            else if (ecn != '0)
                skip_flag = 1'b1;
            else if (!skip_flag)
                v.set_ecn = 1'b1;
            else
                skip_flag = 1'b0;
        end
    endtask

    task automatic report_field(input string name, input longint exp_v, input longint act_v);
        fail_count++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rates_cfg  = RST_PORT_RATES;
            mask_cfg   = RST_MARK_MASK;
            weight_cfg = RST_AVG_WEIGHT;
            ivl_cfg    = RST_INTERVAL_US;
            ceil_cfg   = RST_MAX_PERCENT;
            win_bytes  = '0;
            ewma_bytes = '0;
            win_start  = '0;
            cur_prob   = '0;
            skip_flag  = 1'b0;
            expected_verdicts.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_PORT_RATES:  rates_cfg  = pwdata[RATES_W-1:0];
                    REG_MARK_MASK:   mask_cfg   = pwdata[MASK_W-1:0];
                    REG_AVG_WEIGHT:  weight_cfg = pwdata[WEIGHT_W-1:0];
                    REG_INTERVAL_US: ivl_cfg    = pwdata[IVL_W-1:0];
                    REG_MAX_PERCENT: ceil_cfg   = pwdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_USED_W-1:0];
                if (expected_verdicts.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no request waiting, expected none, got %0d %0d %0d",
                             $time, got.drop, got.set_ecn, got.prob);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.drop !== want.drop)
                        report_field("drop", longint'(want.drop), longint'(got.drop));
                    if (got.set_ecn !== want.set_ecn)
                        report_field("set_ecn", longint'(want.set_ecn), longint'(got.set_ecn));
                    if (got.prob !== want.prob)
                        report_field("probability", longint'(want.prob), longint'(got.prob));
                end
            end
            if (s_tvalid && s_tready) begin
                judge_packet(s_tdata, want);
                expected_verdicts.push_back(want);
            end
            pending = expected_verdicts.size();
        end
    end

endmodule

### tb/tb_rate_based_ecn_marker.sv
// Testbench top for the rate-based ECN marker: clock, reset, APB register
// programming and packet requests; the verdict comes from rbem_checker.
// Depends on rbem_pkg, rbem_checker and the RTL of rate_based_ecn_marker.
module tb_rate_based_ecn_marker;
    timeunit 1ns;
    timeprecision 1ps;

    import rbem_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 200;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    bit                    no_idle = 1'b0;
    logic [TIME_W-1:0]     tb_now;
    int unsigned           cur_ivl;

    rate_based_ecn_marker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rbem_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_packet(input logic [PORT_W-1:0] port, input logic [LEN_W-1:0] len,
                               input logic [TIME_W-1:0] now, input logic [QPK_W-1:0] qpk,
                               input logic [RND_W-1:0] rnd, input logic [ECN_W-1:0] ecn);
        logic [S_TDATA_W-1:0] req;
        int gap;
        req = '0;
        req[IN_PORT_LSB +: PORT_W] = port;
        req[IN_LEN_LSB +: LEN_W]   = len;
        req[IN_NOW_LSB +: TIME_W]  = now;
        req[IN_QPK_LSB +: QPK_W]   = qpk;
        req[IN_RND_LSB +: RND_W]   = rnd;
        req[IN_ECN_LSB +: ECN_W]   = ecn;
        gap = no_idle ? 0 : int'($urandom_range(0, 8));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= req;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!(s_tvalid && s_tready)) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold requests until every verdict is back, then let the block settle
    task automatic wait_queue_empty();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (45) @(negedge aclk);
    endtask

    task automatic program_random_settings();
        logic [RATES_W-1:0]  rates;
        logic [RATE_W-1:0]   r;
        logic [MASK_W-1:0]   mask;
        logic [WEIGHT_W-1:0] weight;
        logic [WEIGHT_W-1:0] ceiling;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 9))
                0: r = '0;
                1: r = '1;
                2, 3: r = RATE_W'($urandom_range(0, 65535));
                default: r = RATE_W'($urandom_range(4096, 65535));
            endcase
            rates[i*RATE_W +: RATE_W] = r;
        end
        case ($urandom_range(0, 3))
            0: mask = '0;
            1: mask = '1;
            default: mask = MASK_W'($urandom_range(0, 15));
        endcase
        case ($urandom_range(0, 5))
            0: weight = '0;
            1: weight = ONE_Q16;
            2: weight = '1;
            default: weight = WEIGHT_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 5))
            0: cur_ivl = 1;
            1: cur_ivl = 32'h00FF_FFFF;
            2: cur_ivl = 1000;
            default: cur_ivl = $urandom_range(2, 20000);
        endcase
        case ($urandom_range(0, 5))
            0: ceiling = '0;
            1: ceiling = ONE_Q16;
            2: ceiling = '1;
            default: ceiling = WEIGHT_W'($urandom_range(1, 65535));
        endcase
        write_reg(REG_PORT_RATES, rates);
        write_reg(REG_MARK_MASK, 64'(mask));
        write_reg(REG_AVG_WEIGHT, 64'(weight));
        write_reg(REG_INTERVAL_US, 64'(cur_ivl));
        write_reg(REG_MAX_PERCENT, 64'(ceiling));
    endtask

    task automatic send_random_packet();
        logic [LEN_W-1:0] len;
        logic [QPK_W-1:0] qpk;
        logic [RND_W-1:0] rnd;
        logic [ECN_W-1:0] ecn;
        logic [TIME_W-1:0] back;
        case ($urandom_range(0, 9))
            0: ;
            1: begin
                back = TIME_W'($urandom_range(0, cur_ivl));
                tb_now = (tb_now > back) ? tb_now - back : '0;
            end
            2: tb_now = tb_now + TIME_W'($urandom_range(0, cur_ivl * 4));
            default: tb_now = tb_now + TIME_W'($urandom_range(0, cur_ivl / 2 + 1));
        endcase
        case ($urandom_range(0, 9))
            0: len = ($urandom_range(0, 1) != 0) ? '1 : '0;
            1, 2: len = LEN_W'($urandom_range(0, 65535));
            default: len = LEN_W'($urandom_range(40, 1500));
        endcase
        case ($urandom_range(0, 9))
            0: qpk = ($urandom_range(0, 1) != 0) ? '1 : '0;
            1, 2: qpk = QPK_W'($urandom_range(0, 65535));
            default: qpk = QPK_W'($urandom_range(0, 8));
        endcase
        rnd = RND_W'($urandom_range(0, 65535) >> $urandom_range(0, 14));
        ecn = ($urandom_range(0, 3) == 0) ? ECN_W'($urandom_range(1, 3)) : '0;
        send_packet(PORT_W'($urandom_range(0, 3)), len, tb_now, qpk, rnd, ecn);
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            int stall;
            stall = no_idle ? 0 : int'($urandom_range(0, 8));
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        tb_now   = '0;
        cur_ivl  = 1000;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // register defaults, dropping on every port
        send_packet(2'd0, 16'd0, 40'd0, 16'd0, 16'd0, 2'd0);
        send_packet(2'd1, 16'hFFFF, 40'd400, 16'hFFFF, 16'hFFFF, 2'd3);
        send_packet(2'd2, 16'd1500, 40'd1000, 16'd10, 16'd0, 2'd1);
        send_packet(2'd3, 16'd64, 40'd1200, 16'd0, 16'hFFFF, 2'd2);
        wait_queue_empty();

        // marking on ports 0..2, zero rate on port 3, full weight
        write_reg(REG_PORT_RATES, 64'h0000_FFFF_8000_FFFF);
        write_reg(REG_MARK_MASK, 64'h7);
        write_reg(REG_AVG_WEIGHT, 64'(ONE_Q16));
        write_reg(REG_INTERVAL_US, 64'd1);
        write_reg(REG_MAX_PERCENT, 64'(ONE_Q16));
        send_packet(2'd0, 16'd1000, 40'd3000, 16'd0, 16'd0, 2'd0);
        send_packet(2'd1, 16'd1000, 40'd3000, 16'd0, 16'd0, 2'd2);
        send_packet(2'd2, 16'd1000, 40'd3000, 16'd0, 16'd0, 2'd0);
        send_packet(2'd0, 16'd1000, 40'd3000, 16'd0, 16'd0, 2'd0);
        send_packet(2'd0, 16'd0, 40'd2000, 16'd0, 16'd0, 2'd0);
        send_packet(2'd0, 16'd0, 40'd3000, 16'd0, 16'd300, 2'd0);
        send_packet(2'd3, 16'd500, 40'd4000, 16'd0, 16'd0, 2'd0);
        send_packet(2'd1, 16'd500, 40'd6000, 16'd0, 16'd100, 2'd0);
        wait_queue_empty();

        write_reg(REG_MAX_PERCENT, 64'd0);
        write_reg(REG_AVG_WEIGHT, 64'd0);
        send_packet(2'd2, 16'd100, 40'd8000, 16'd5, 16'd0, 2'd0);
        wait_queue_empty();

        write_reg(REG_AVG_WEIGHT, 64'h1_FFFF);
        write_reg(REG_MAX_PERCENT, 64'h1_FFFF);
        send_packet(2'd0, 16'd1500, 40'd9000, 16'd3, 16'd0, 2'd0);
        send_packet(2'd1, 16'd800, 40'd9000, 16'd0, 16'hFFFF, 2'd1);
        tb_now = 40'd9000;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_queue_empty();
            program_random_settings();
            tb_now = tb_now + TIME_W'($urandom_range(0, 1 << 20));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_random_packet();
            end
        end
        no_idle = 1'b0;

        // top of the time range
        wait_queue_empty();
        write_reg(REG_INTERVAL_US, 64'd1000);
        send_packet(2'd0, 16'd100, 40'hFF_FFFF_FFFF, 16'd0, 16'd0, 2'd0);
        send_packet(2'd1, 16'd200, 40'hFF_FFFF_FFFF, 16'd1, 16'd5, 2'd0);
        wait_queue_empty();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/rbem_pkg.sv
rtl/rbem_cfg.sv
rtl/rbem_ctrl.sv
rtl/rbem_dp.sv
rtl/rate_based_ecn_marker.sv
tb/rbem_checker.sv
tb/tb_rate_based_ecn_marker.sv
